>>> hw/rtl/esc_pkg.sv
package esc_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAYDIV,
        ST_DAYREM,
        ST_YEAR,
        ST_MONTH,
        ST_HOUR,
        ST_HOURREM,
        ST_MIN,
        ST_MINREM,
        ST_DONE
    } t_state;

    // reciprocals for the constant divisions, each exact over its input range
    // 86400 = 675 << 7, days = ((secs >> 7) * ceil(2^35 / 675)) >> 35
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [9:0]  DAY_ODD       = 10'd675;
    // 3600 = 225 << 4, hour = ((sod >> 4) * ceil(2^21 / 225)) >> 21
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;
    // 60 = 15 << 2, minute = ((rem >> 2) * ceil(2^14 / 15)) >> 14
    localparam logic [10:0] MIN_RECIP     = 11'd1093;

    // calendar constants
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [8:0]  DAYS_COMMON   = 9'd365;
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;
    // year offset of 1970 from 2000
    localparam logic signed [7:0] EPOCH_YOFF = 8'(1970 - 2000);
    // year 2100 as offset; the only century year in range that is common
    localparam logic signed [7:0] YOFF_2100  = 8'(2100 - 2000);

    // leap rule over 1970..2106: 2000 is leap, 2100 is not
    function automatic logic is_leap(input logic signed [7:0] yoff);
        is_leap = (yoff[1:0] == 2'b00) && (yoff != YOFF_2100);
    endfunction

    // month length, month counted from 0
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

>>> hw/rtl/epoch_seconds_to_calendar.sv
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date and time of day, year given as a signed offset from 2000 (1970..2106).
// One request is converted at a time. The divisions by 86400, 3600 and 60 are constant
// reciprocal multiplies; their remainders, the year walk and the month walk all go through
// a single shared 18-bit subtract/compare unit. The walks step once per elapsed year and
// once per elapsed month; the year walk takes the longest. The input side is ready only
// while the sequencer is idle, so a new request is taken only after the previous one has
// left the sequencer. A finished result sits in an output register until taken and a new
// request may be accepted meanwhile; the result after it then waits in the sequencer,
// holding off further requests, until the output register frees.
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] epoch_seconds
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] years_since_2000, [11:8] month_number, [16:12] day_of_month,
    // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute, [39:34] zero
    output logic [39:0] o_m_axis_tdata
);

    t_state             r_state, n_state;
    logic [31:0]        r_secs, n_secs;
    logic [15:0]        r_days, n_days;
    logic [16:0]        r_sod, n_sod;
    logic [11:0]        r_rem, n_rem;
    logic signed [7:0]  r_year, n_year;
    logic [3:0]         r_month, n_month;
    logic [4:0]         r_hour, n_hour;
    logic [5:0]         r_min, n_min;
    logic               r_out_valid, n_out_valid;
    logic [39:0]        r_out_data, n_out_data;

    logic        w_accept;
    logic        w_leap;
    logic [50:0] w_day_prod;
    logic [9:0]  w_day_back;
    logic [26:0] w_hour_prod;
    logic [16:0] w_hour_back;
    logic [20:0] w_min_prod;
    logic [11:0] w_min_back;
    logic [17:0] u_a, u_b, u_diff;
    logic        u_ge;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_leap   = is_leap(r_year);

    // whole days as (secs >> 7) / 675 by reciprocal multiply
    assign w_day_prod  = {26'd0, r_secs[31:7]} * {25'd0, DAY_RECIP};
    // day remainder is below 675, so the ten low bits of days * 675 suffice
    assign w_day_back  = r_days[9:0] * DAY_ODD;
    // hour as (sod >> 4) / 225
    assign w_hour_prod = {14'd0, r_sod[16:4]} * {13'd0, HOUR_RECIP};
    assign w_hour_back = {12'd0, r_hour} * SECS_PER_HOUR;
    // minute as (rem >> 2) / 15
    assign w_min_prod  = {11'd0, r_rem[11:2]} * {10'd0, MIN_RECIP};
    assign w_min_back  = {6'd0, r_min} * SECS_PER_MIN;

    // shared subtract/compare unit operand select
    always_comb begin
        unique case (r_state)
            ST_DAYREM: begin
                u_a = {8'd0, r_secs[16:7]};
                u_b = {8'd0, w_day_back};
            end
            ST_YEAR: begin
                u_a = {2'b00, r_days};
                u_b = {9'd0, (w_leap ? DAYS_LEAP : DAYS_COMMON)};
            end
            ST_MONTH: begin
                u_a = {2'b00, r_days};
                u_b = {13'd0, month_len(r_month, w_leap)};
            end
            ST_HOURREM: begin
                u_a = {1'b0, r_sod};
                u_b = {1'b0, w_hour_back};
            end
            ST_MINREM: begin
                u_a = {6'd0, r_rem};
                u_b = {6'd0, w_min_back};
            end
            default: begin
                u_a = 18'd0;
                u_b = 18'd0;
            end
        endcase
    end

    // shared subtractor, borrow out gives the compare
    always_comb begin
        logic [18:0] diff;
        diff   = {1'b0, u_a} - {1'b0, u_b};
        u_diff = diff[17:0];
        u_ge   = !diff[18];
    end

    // sequencer next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_secs      = r_secs;
        n_rem       = r_rem;
        n_days      = r_days;
        n_sod       = r_sod;
        n_year      = r_year;
        n_month     = r_month;
        n_hour      = r_hour;
        n_min       = r_min;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // result taken downstream
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_secs  = i_s_axis_tdata;
                    n_state = ST_DAYDIV;
                end
            end
            ST_DAYDIV: begin
                n_days  = w_day_prod[50:35];
                n_state = ST_DAYREM;
            end
            ST_DAYREM: begin
                n_sod   = {u_diff[9:0], r_secs[6:0]};
                n_year  = EPOCH_YOFF;
                n_state = ST_YEAR;
            end
            ST_YEAR: begin
                if (r_days > {7'd0, DAYS_COMMON}) begin
                    n_days = u_diff[15:0];
                    n_year = r_year + 8'sd1;
                end else begin
                    // a whole common year left: roll over to january 1
                    if ((r_days == {7'd0, DAYS_COMMON}) && !w_leap) begin
                        n_days = 16'd0;
                        n_year = r_year + 8'sd1;
                    end
                    n_month = 4'd0;
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if ((r_month != LAST_MONTH) && u_ge) begin
                    n_days  = u_diff[15:0];
                    n_month = r_month + 4'd1;
                end else begin
                    n_state = ST_HOUR;
                end
            end
            ST_HOUR: begin
                n_hour  = w_hour_prod[25:21];
                n_state = ST_HOURREM;
            end
            ST_HOURREM: begin
                n_rem   = u_diff[11:0];
                n_state = ST_MIN;
            end
            ST_MIN: begin
                n_min   = w_min_prod[19:14];
                n_state = ST_MINREM;
            end
            ST_MINREM: begin
                n_rem   = {6'd0, u_diff[5:0]};
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_rem[5:0], r_min, r_hour,
                                   r_days[4:0] + 5'd1, r_month + 4'd1, r_year};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_secs     <= n_secs;
        r_rem      <= n_rem;
        r_days     <= n_days;
        r_sod      <= n_sod;
        r_year     <= n_year;
        r_month    <= n_month;
        r_hour     <= n_hour;
        r_min      <= n_min;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // a request always starts the day division
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DAYDIV))
        else $error("accepted request did not start day division");

    // month walk leaves a day index inside the month
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOUR) |-> ((r_month <= LAST_MONTH) && (r_days <= 16'd30)))
        else $error("month walk left out-of-range month or day");

    // hour quotient stays inside the day
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOURREM) |-> (r_hour <= 5'd23))
        else $error("hour quotient out of range");

    // remainders stay below their divisors
    a_hour_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIN) |-> ({5'd0, r_rem} < SECS_PER_HOUR))
        else $error("hour division remainder out of range");

    a_min_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_rem < SECS_PER_MIN))
        else $error("minute division remainder out of range");

    // a delivered month is always 1..12
    a_out_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[11:8] != 4'd0) && (o_m_axis_tdata[11:8] <= 4'd12)))
        else $error("result month out of range");

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // one result word, fields from the top bit down to match the output bus
    typedef struct packed {
        logic [5:0]        pad;
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [3:0]        month;
        logic signed [7:0] year;
    } t_cal;

    typedef struct {
        logic [31:0] secs;
        bit          drain;
    } t_pending;

    typedef struct {
        logic [31:0] secs;
        t_cal        cal;
    } t_cal_expect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    t_cal        m_data;

    t_pending    pending_secs[$];
    t_cal_expect cal_expect[$];
    int          errors = 0;
    int          accepted_cnt = 0;
    bit          s_taken = 1'b0;
    int          s_gap = 0;
    bit          s_calm = 1'b0;
    int          r_hold = 0;
    bit          r_calm = 1'b0;
    bit          long_hold_done = 1'b0;

    epoch_seconds_to_calendar uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // full gregorian rule
    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days from the epoch to january 1 of year y
    function automatic int year_start_days(input int y);
        int d;
        d = 0;
        for (int k = 1970; k < y; k++) d += leap_year(k) ? 366 : 365;
        return d;
    endfunction

    // expected date and time of day for one request
    function automatic t_cal calendar_of(input logic [31:0] secs);
        int unsigned day_cnt;
        int unsigned rem_secs;
        int          yr;
        int          mon;
        int          month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        bit          leap;
        bit          walking;
        t_cal        c;
        day_cnt  = secs / 86400;
        rem_secs = secs % 86400;
        yr       = 1970;
        // strip whole years
        while (day_cnt > 365) begin
            day_cnt -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        // a full common year left over rolls into january 1
        if (day_cnt == 365 && !leap_year(yr)) begin
            day_cnt = 0;
            yr++;
        end
        leap    = leap_year(yr);
        mon     = 0;
        walking = 1'b1;
        // strip whole months
        while (walking && mon < 11) begin
            if (day_cnt >= month_days[mon] + ((mon == 1 && leap) ? 1 : 0)) begin
                day_cnt -= month_days[mon] + ((mon == 1 && leap) ? 1 : 0);
                mon++;
            end else begin
                walking = 1'b0;
            end
        end
        c.pad    = '0;
        c.year   = 8'(yr - 2000);
        c.month  = 4'(mon + 1);
        c.day    = 5'(day_cnt + 1);
        c.hour   = 5'(rem_secs / 3600);
        c.minute = 6'((rem_secs % 3600) / 60);
        c.second = 6'(rem_secs % 60);
        return c;
    endfunction

    // idle length: mostly short, now and then long, none in calm stretches
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_err(input string what, input logic [31:0] secs,
                              input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s for request %0d: got %h want %h", what, secs, got, want);
        errors++;
    endtask

    task automatic add_item(input logic [31:0] secs, input bit drain);
        t_pending p;
        p.secs  = secs;
        p.drain = drain;
        pending_secs.push_back(p);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_gap > 0) begin
                s_valid <= 1'b0;
                s_gap   <= s_gap - 1;
            end else if (pending_secs.size() > 0 &&
                         !(pending_secs[0].drain && cal_expect.size() != 0)) begin
                s_valid <= 1'b1;
                s_data  <= pending_secs[0].secs;
                void'(pending_secs.pop_front());
                s_gap   <= idle_len(s_calm);
            end else begin
                s_valid <= 1'b0;
            end
            if ($urandom_range(0, 149) == 0) s_calm <= !s_calm;
        end
    end

    // request capture and prediction
    always @(posedge i_clk) begin : capture
        t_cal_expect e;
        s_taken <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && s_valid && s_ready) begin
            e.secs = s_data;
            e.cal  = calendar_of(s_data);
            cal_expect.push_back(e);
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (r_hold > 0) begin
            m_ready <= 1'b0;
            r_hold  <= r_hold - 1;
        end else if (!long_hold_done && accepted_cnt >= 400) begin
            m_ready        <= 1'b0;
            r_hold         <= 3000;
            long_hold_done <= 1'b1;
        end else if ($urandom_range(0, 9) == 0 && idle_len(r_calm) > 0) begin
            m_ready <= 1'b0;
            r_hold  <= idle_len(r_calm);
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 149) == 0) r_calm <= !r_calm;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : monitor
        t_cal_expect e;
        if (i_rst_n && m_valid && m_ready) begin
            if (cal_expect.size() == 0) begin
                report_err("unrequested result", '0, m_data, '0);
            end else begin
                e = cal_expect.pop_front();
                if (m_data.year !== e.cal.year)
                    report_err("year", e.secs, 40'(m_data.year), 40'(e.cal.year));
                if (m_data.month !== e.cal.month)
                    report_err("month", e.secs, 40'(m_data.month), 40'(e.cal.month));
                if (m_data.day !== e.cal.day)
                    report_err("day", e.secs, 40'(m_data.day), 40'(e.cal.day));
                if (m_data.hour !== e.cal.hour)
                    report_err("hour", e.secs, 40'(m_data.hour), 40'(e.cal.hour));
                if (m_data.minute !== e.cal.minute)
                    report_err("minute", e.secs, 40'(m_data.minute), 40'(e.cal.minute));
                if (m_data.second !== e.cal.second)
                    report_err("second", e.secs, 40'(m_data.second), 40'(e.cal.second));
                if (m_data.pad !== e.cal.pad)
                    report_err("padding", e.secs, 40'(m_data.pad), 40'(e.cal.pad));
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stim
        int          pick;
        int          yr;
        longint      val;
        logic [31:0] directed_secs[25] = '{
            32'd0,          32'd59,         32'd3599,       32'd86399,
            32'd86400,      32'd31535999,   32'd31536000,   32'd68169600,
            32'd94608000,   32'd94694400,   32'd946684799,  32'd946684800,
            32'd951782400,  32'd978220800,  32'd978307200,  32'd2147483647,
            32'd2147483648, 32'd4102444800, 32'd4107456000, 32'd4107542400,
            32'd4133894400, 32'd4133980800, 32'd4294967295, 32'h55555555,
            32'haaaaaaaa
        };
        // epoch, day and year edges, leap days, year 2000 and 2100, top of range
        foreach (directed_secs[i]) add_item(directed_secs[i], 1'b0);
        // random part, weighted toward year and day edges
        for (int n = 0; n < 1325; n++) begin
            pick = $urandom_range(0, 99);
            yr   = $urandom_range(1971, 2106);
            if (pick < 40) begin
                val = longint'($urandom);
            end else if (pick < 65) begin
                val = longint'(year_start_days(yr)) * 86400
                      + longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
            end else if (pick < 85) begin
                val = longint'(year_start_days(yr) + $urandom_range(0, 365)) * 86400
                      + longint'($urandom_range(0, 20)) - 10;
            end else if (pick < 93) begin
                val = longint'($urandom_range(0, 2 * 366 * 86400));
            end else begin
                val = 64'hffffffff - longint'($urandom_range(0, 200000000));
            end
            if (val < 0) val = 0;
            if (val > 64'hffffffff) val = 64'hffffffff;
            add_item(val[31:0], n == 0 || n == 650);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_secs.size() != 0 || s_valid) @(posedge i_clk);
        while (cal_expect.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
